// ===== rtl/tcts_pkg.sv =====
package tcts_pkg;

    localparam logic [3:0] START_LEN = 4'd11;
    localparam logic [3:0] END_LEN   = 4'd12;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);

    localparam logic [7:0] CH_LT = 8'h3c;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam logic [7:0] START_TAG [0:10] = '{
        8'h3c, 8'h74, 8'h6f, 8'h6f, 8'h6c, 8'h5f, 8'h63, 8'h61, 8'h6c, 8'h6c, 8'h3e
    };
    localparam logic [7:0] END_TAG [0:11] = '{
        8'h3c, 8'h2f, 8'h74, 8'h6f, 8'h6f, 8'h6c, 8'h5f, 8'h63, 8'h61, 8'h6c, 8'h6c, 8'h3e
    };

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_BODY    = 2'd1,
        KIND_END     = 2'd2,
        KIND_ABORT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        TR_NONE  = 2'd0,
        TR_BYTE  = 2'd1,
        TR_END   = 2'd2,
        TR_ABORT = 2'd3
    } t_trail;

    // One job: a run of held tag characters, then an optional trailing result.
    typedef struct packed {
        logic        in_call;
        logic [3:0]  held;
        logic [15:0] num;
        t_trail      trail;
        logic [7:0]  tbyte;
    } t_job;

    function automatic logic [7:0] tag_char(input logic in_call, input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (in_call) begin
            if (idx < END_LEN) begin
                ch = END_TAG[idx];
            end
        end else begin
            if (idx < START_LEN) begin
                ch = START_TAG[idx];
            end
        end
        return ch;
    endfunction

endpackage

// ===== rtl/tcts_if.sv =====
interface tcts_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, command, in_byte, input ready);
    modport sink (input valid, command, in_byte, output ready);
endinterface

interface tcts_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] call_number;
    logic        last;

    modport source (output valid, out_byte, kind, call_number, last, input ready);
    modport sink (input valid, out_byte, kind, call_number, last, output ready);
endinterface

// ===== rtl/tcts_front.sv =====
module tcts_front
    import tcts_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcts_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_job         o_job
);

    logic               r_inside;
    logic [3:0]         r_matched;
    logic               r_skip;
    logic [ID_BITS-1:0] r_cnt;

    logic               n_inside;
    logic [3:0]         n_matched;
    logic               n_skip;
    logic [ID_BITS-1:0] n_cnt;

    logic                w_acc;
    logic [7:0]          w_c;
    logic [7:0]          w_tch;
    logic [3:0]          w_len;
    logic [ID_BITS+15:0] w_ext;
    logic [15:0]         w_num;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_c        = i_in.in_byte;
    assign w_ext      = {16'd0, r_cnt};
    assign w_num      = w_ext[15:0];
    assign w_tch      = tag_char(r_inside, r_matched);
    assign w_len      = r_inside ? END_LEN : START_LEN;

    always_comb begin
        n_inside    = r_inside;
        n_matched   = r_matched;
        n_skip      = r_skip;
        n_cnt       = r_cnt;
        o_push      = 1'b0;
        o_job.in_call = r_inside;
        o_job.held  = 4'd0;
        o_job.num   = w_num;
        o_job.trail = TR_NONE;
        o_job.tbyte = w_c;
        if (w_acc) begin
            if (i_in.command) begin
                o_job.held  = r_matched;
                o_job.trail = r_inside ? TR_ABORT : TR_NONE;
                o_push      = (r_matched != 4'd0) || r_inside;
                n_inside    = 1'b0;
                n_matched   = 4'd0;
                n_skip      = 1'b0;
            end else if (r_skip && (w_c == CH_LF || w_c == CH_CR)) begin
                n_skip = 1'b1;
            end else begin
                n_skip = 1'b0;
                if (w_c == w_tch) begin
                    if (r_matched + 4'd1 == w_len) begin
                        n_matched = 4'd0;
                        n_skip    = 1'b1;
                        if (r_inside) begin
                            o_job.trail = TR_END;
                            o_push      = 1'b1;
                            n_cnt       = r_cnt + {{(ID_BITS-1){1'b0}}, 1'b1};
                            n_inside    = 1'b0;
                        end else begin
                            n_inside = 1'b1;
                        end
                    end else begin
                        n_matched = r_matched + 4'd1;
                    end
                end else begin
                    o_job.held = r_matched;
                    if (w_c == CH_LT) begin
                        n_matched = 4'd1;
                        o_push    = (r_matched != 4'd0);
                    end else begin
                        n_matched   = 4'd0;
                        o_job.trail = TR_BYTE;
                        o_push      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_matched <= 4'd0;
            r_skip    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_inside  <= n_inside;
            r_matched <= n_matched;
            r_skip    <= n_skip;
            r_cnt     <= n_cnt;
        end
    end

    // The held prefix is always shorter than the tag being matched.
    a_matched_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched < w_len)
        else $error("held tag prefix reached the full tag length");

    // Newline skipping only starts right after a completed tag.
    a_skip_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_matched == 4'd0))
        else $error("newline skip active while tag characters are held");

endmodule

// ===== rtl/tcts_queue.sv =====
module tcts_queue
    import tcts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("job queue written while full");

endmodule

// ===== rtl/tcts_back.sv =====
module tcts_back
    import tcts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    tcts_out_if.source  o_out
);

    logic        r_ov;
    logic [7:0]  r_byte;
    t_kind       r_kind;
    logic [15:0] r_num;
    logic        r_last;
    logic [3:0]  r_idx;

    logic        w_adv;
    logic        w_take;
    logic [3:0]  w_total;
    logic        w_is_last;
    logic [7:0]  w_byte;
    t_kind       w_kind;
    logic [15:0] w_num;

    assign w_adv     = !r_ov || o_out.ready;
    assign w_take    = w_adv && !i_empty;
    assign w_total   = i_head.held + {3'd0, (i_head.trail != TR_NONE)};
    assign w_is_last = (r_idx + 4'd1 == w_total);
    assign o_pop     = w_take && w_is_last;

    always_comb begin
        w_byte = 8'h00;
        w_kind = i_head.in_call ? KIND_BODY : KIND_CONTENT;
        w_num  = i_head.in_call ? i_head.num : 16'd0;
        if (r_idx < i_head.held) begin
            w_byte = tag_char(i_head.in_call, r_idx);
        end else begin
            case (i_head.trail)
                TR_BYTE: begin
                    w_byte = i_head.tbyte;
                end
                TR_END: begin
                    w_kind = KIND_END;
                    w_num  = i_head.num;
                end
                TR_ABORT: begin
                    w_kind = KIND_ABORT;
                    w_num  = i_head.num;
                end
                default: begin
                    w_byte = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= w_byte;
            r_kind <= w_kind;
            r_num  <= w_num;
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 4'd0;
        end else begin
            if (w_adv) begin
                r_ov <= !i_empty;
            end
            if (w_take) begin
                r_idx <= w_is_last ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_byte;
    assign o_out.kind        = r_kind;
    assign o_out.call_number = r_num;
    assign o_out.last        = r_last;

    // The word index never runs past the end of the job at the queue head.
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < w_total))
        else $error("result index ran past the job length");

endmodule

// ===== rtl/tool_call_tag_splitter.sv =====
// Splits a text byte stream around the start and end tags of a tool call. Each input word is a
// data byte or a flush, and the block accepts one input word per clock cycle. Tag bytes and
// line breaks right after a tag are stripped, and every other byte comes out as one result
// word tagged as content or call body; a closed call gives a call-end word and a flush inside
// an open call gives an abort word. The front end classifies each byte and writes at most one
// job into a four-entry queue; the back end expands each job into results at one word per
// cycle while the output is ready, through a registered output. A byte that breaks a partly
// matched tag releases the held tag characters, so one input word may cause up to 12 results;
// input stalls only on a full job queue. The last result of every input word carries last set.
module tool_call_tag_splitter
    import tcts_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcts_in_if.sink     i_in,
    tcts_out_if.source  o_out
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job;
    t_job w_head;

    tcts_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    tcts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tcts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
